[sv/sslp_pkg.sv]
// Shared types and constants of the system-exclusive LED command parser.
// No dependencies; used by the configuration registers, the parser and the top level.
package sslp_pkg;

  // Command and marker bytes found in command position.
  localparam logic [7:0] CmdOrange = 8'h10;
  localparam logic [7:0] CmdBlue   = 8'h11;
  localparam logic [7:0] CmdRgb    = 8'h20;
  localparam logic [7:0] CmdError  = 8'h30;
  localparam logic [7:0] CmdBeat   = 8'h40;
  localparam logic [7:0] ByteEnd   = 8'hF7;

  // Width of the prefix length register and of the prefix position.
  localparam int unsigned PosW = 4;

  // Event codes carried on the result channel.
  typedef enum logic [2:0] {
    KindBeat   = 3'd0,
    KindOrange = 3'd1,
    KindBlue   = 3'd2,
    KindColor  = 3'd3,
    KindError  = 3'd4
  } kind_e;

  // Parse phase, one-hot.
  typedef enum logic [5:0] {
    PhPrefix = 6'b000001,
    PhCmd    = 6'b000010,
    PhOrange = 6'b000100,
    PhBlue   = 6'b001000,
    PhColor  = 6'b010000,
    PhStop   = 6'b100000
  } phase_e;

  // Configuration register contents.
  typedef struct packed {
    logic [63:0]     prefix_bytes;
    logic [PosW-1:0] prefix_length;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    kind_e      event_kind;
    logic [2:0] led_index;
    logic [7:0] level_or_red;
    logic [7:0] green_level;
    logic [7:0] blue_component;
  } event_t;

  // Handshake into the parser: valid from the input stage, ready from downstream.
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_hs_t;

endpackage

[sv/sslp_cfg_regs.sv]
// APB-style configuration registers of the parser: prefix bytes and prefix length.
// Depends on sslp_pkg for the register struct.
module sslp_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output sslp_pkg::cfg_t     cfg_o
);

  logic [63:0]               prefix_bytes_q, prefix_bytes_d;
  logic [sslp_pkg::PosW-1:0] prefix_length_q, prefix_length_d;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Address bit 3 selects the register; the lower bits are not decoded.
  always_comb begin
    prefix_bytes_d  = prefix_bytes_q;
    prefix_length_d = prefix_length_q;
    if (wr_en) begin
      if (paddr[3]) begin
        prefix_length_d = pwdata[sslp_pkg::PosW-1:0];
      end else begin
        prefix_bytes_d = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_bytes_q  <= '0;
      prefix_length_q <= '0;
    end else begin
      prefix_bytes_q  <= prefix_bytes_d;
      prefix_length_q <= prefix_length_d;
    end
  end

  // Read data follows the same decode.
  assign prdata = paddr[3] ? {{(64 - sslp_pkg::PosW){1'b0}}, prefix_length_q}
                           : prefix_bytes_q;

  assign cfg_o.prefix_bytes  = prefix_bytes_q;
  assign cfg_o.prefix_length = prefix_length_q;

endmodule

[sv/sslp_parser.sv]
// Parse state, single-pass byte decode and result register of the parser.
// Depends on sslp_pkg for the phase, event and configuration types.
module sslp_parser #(
  parameter int unsigned LED_COUNT  = 8,
  parameter int unsigned PREFIX_MAX = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sslp_pkg::cfg_t     cfg_i,
  input  sslp_pkg::in_beat_t beat_i,
  input  sslp_pkg::stage_hs_t hs_i,   // valid from the input stage, ready from downstream
  output logic               take_o,  // the input stage beat is consumed this cycle
  output logic               out_valid_o,
  output sslp_pkg::event_t   event_o
);

  localparam logic [7:0] LedLimit = 8'(sslp_pkg::CmdRgb + 8'(LED_COUNT));
  localparam logic [sslp_pkg::PosW-1:0] PrefixMaxW = sslp_pkg::PosW'(PREFIX_MAX);

  sslp_pkg::phase_e          phase_q, phase_d;
  logic [sslp_pkg::PosW-1:0] pos_q, pos_d;
  logic [2:0]                held_index_q, held_index_d;
  logic [7:0]                held_red_q, held_red_d;
  logic [7:0]                held_green_q, held_green_d;
  logic [1:0]                count_q, count_d;

  logic                      out_valid_q, out_valid_d;
  sslp_pkg::event_t          event_q, event_d;

  logic [7:0]                b;
  logic                      eom;
  logic [sslp_pkg::PosW-1:0] plen;
  logic [7:0]                want;

  // Command-position decode results.
  sslp_pkg::phase_e          cmd_phase;
  logic                      cmd_emit;
  sslp_pkg::kind_e           cmd_kind;
  logic                      cmd_load;

  logic                      emit;
  sslp_pkg::event_t          ev;

  assign b   = beat_i.data_byte;
  assign eom = beat_i.end_of_message;

  // The parser advances whenever the result register is free or being emptied.
  assign take_o = hs_i.valid && (!out_valid_q || hs_i.ready);

  assign plen = (cfg_i.prefix_length > PrefixMaxW) ? PrefixMaxW : cfg_i.prefix_length;
  assign want = cfg_i.prefix_bytes[pos_q[2:0]*8 +: 8];

  // Decode of a byte standing in command position.
  always_comb begin
    cmd_phase = sslp_pkg::PhCmd;
    cmd_emit  = 1'b0;
    cmd_kind  = sslp_pkg::KindError;
    cmd_load  = 1'b0;
    if (b == sslp_pkg::ByteEnd) begin
      cmd_phase = sslp_pkg::PhStop;
    end else if (b == sslp_pkg::CmdBeat) begin
      cmd_emit = 1'b1;
      cmd_kind = sslp_pkg::KindBeat;
    end else if (b == sslp_pkg::CmdOrange) begin
      cmd_phase = eom ? sslp_pkg::PhStop : sslp_pkg::PhOrange;
      cmd_emit  = eom;
    end else if (b == sslp_pkg::CmdBlue) begin
      cmd_phase = eom ? sslp_pkg::PhStop : sslp_pkg::PhBlue;
    end else if (b == sslp_pkg::CmdError || b < sslp_pkg::CmdRgb || b >= LedLimit || eom) begin
      cmd_phase = sslp_pkg::PhStop;
      cmd_emit  = 1'b1;
    end else begin
      cmd_phase = sslp_pkg::PhColor;
      cmd_load  = 1'b1;
    end
  end

  // Next parse state and event for the byte in the input stage.
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    held_index_d = held_index_q;
    held_red_d   = held_red_q;
    held_green_d = held_green_q;
    count_d      = count_q;
    emit         = 1'b0;
    ev           = '{event_kind: sslp_pkg::KindError, led_index: 3'd0,
                     level_or_red: 8'd0, green_level: 8'd0, blue_component: 8'd0};

    unique case (phase_q)
      sslp_pkg::PhPrefix: begin
        if (pos_q < plen) begin
          if (b != want) begin
            phase_d = sslp_pkg::PhStop;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end else begin
          phase_d       = cmd_phase;
          emit          = cmd_emit;
          ev.event_kind = cmd_kind;
        end
      end
      sslp_pkg::PhCmd: begin
        phase_d       = cmd_phase;
        emit          = cmd_emit;
        ev.event_kind = cmd_kind;
      end
      sslp_pkg::PhOrange: begin
        phase_d         = sslp_pkg::PhCmd;
        emit            = 1'b1;
        ev.event_kind   = sslp_pkg::KindOrange;
        ev.level_or_red = b;
      end
      sslp_pkg::PhBlue: begin
        phase_d         = sslp_pkg::PhCmd;
        emit            = 1'b1;
        ev.event_kind   = sslp_pkg::KindBlue;
        ev.level_or_red = b;
      end
      sslp_pkg::PhColor: begin
        if (count_q[1] == 1'b0) begin
          if (count_q[0] == 1'b0) begin
            held_red_d = b;
          end else begin
            held_green_d = b;
          end
          count_d = count_q + 1'b1;
          if (eom) begin
            phase_d = sslp_pkg::PhStop;
            emit    = 1'b1;
          end
        end else begin
          count_d           = 2'd0;
          phase_d           = sslp_pkg::PhCmd;
          emit              = 1'b1;
          ev.event_kind     = sslp_pkg::KindColor;
          ev.led_index      = held_index_q;
          ev.level_or_red   = held_red_q;
          ev.green_level    = held_green_q;
          ev.blue_component = b;
        end
      end
      sslp_pkg::PhStop: begin
      end
      default: begin
      end
    endcase

    // A colour command latches its LED number and restarts the byte count.
    if (cmd_load && (phase_q == sslp_pkg::PhCmd ||
                     (phase_q == sslp_pkg::PhPrefix && !(pos_q < plen)))) begin
      held_index_d = b[2:0] - sslp_pkg::CmdRgb[2:0];
      count_d      = 2'd0;
    end

    // The end of a message always returns to prefix matching.
    if (eom) begin
      phase_d = sslp_pkg::PhPrefix;
      pos_d   = '0;
      count_d = 2'd0;
    end

    if (!take_o) begin
      phase_d      = phase_q;
      pos_d        = pos_q;
      held_index_d = held_index_q;
      held_red_d   = held_red_q;
      held_green_d = held_green_q;
      count_d      = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sslp_pkg::PhPrefix;
      pos_q        <= '0;
      held_index_q <= '0;
      held_red_q   <= '0;
      held_green_q <= '0;
      count_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      held_index_q <= held_index_d;
      held_red_q   <= held_red_d;
      held_green_q <= held_green_d;
      count_q      <= count_d;
    end
  end

  // Result register: loaded when a beat is consumed, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    event_d     = event_q;
    if (out_valid_q && hs_i.ready) begin
      out_valid_d = 1'b0;
    end
    if (take_o) begin
      out_valid_d = emit;
      event_d     = ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    event_q <= event_d;
  end

  assign out_valid_o = out_valid_q;
  assign event_o     = event_q;

`ifndef SYNTHESIS
  a_color_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_q.event_kind == sslp_pkg::KindColor
      |-> 32'(event_q.led_index) < LED_COUNT)
    else $error("colour event with LED number out of range");

  a_plain_event_no_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_q.event_kind != sslp_pkg::KindColor
      |-> event_q.green_level == 8'd0 && event_q.blue_component == 8'd0)
    else $error("non-colour event carries colour components");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("colour byte count overran");

  a_eom_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && eom |=> phase_q == sslp_pkg::PhPrefix && pos_q == '0)
    else $error("end of message did not restart prefix matching");
`endif

endmodule

[sv/sysex_led_command_parser_top.sv]
// Top level of the system-exclusive LED command parser.
// Depends on sslp_pkg, sslp_cfg_regs and sslp_parser.
//
// Usage: message bytes arrive on the slave stream, one byte per beat, with
// tlast set on the last byte of each message. Each completed command leaves
// one event on the master stream; bytes that complete nothing leave none.
// Configuration sits on an APB-style port: prefix bytes at 0x0, prefix
// length at 0x8. Write it only while no bytes are in flight.
// An accepted byte is held in the input register; when the parser takes it,
// the event that the byte completes is loaded into the result register,
// which drives the master stream.
// Throughput: one byte per cycle unless the receiver stalls, set by the single
// decode pass between the input register and the result register.
// Reset clears the registers, the parse state (back to prefix matching) and
// both stream stages. When the receiver stalls, the event waits in the
// result register; the input register still takes one more byte if it is empty,
// after which tready falls until the event is taken.
module sysex_led_command_parser_top #(
  parameter int unsigned LED_COUNT  = 8,
  parameter int unsigned PREFIX_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  // Event stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] led_index, [10:3] level_or_red,
                                      // [18:11] green_level, [26:19] blue_component
  output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  sslp_pkg::cfg_t      cfg;
  sslp_pkg::in_beat_t  in_beat_q, in_beat_d;
  logic                in_valid_q, in_valid_d;
  logic                take;
  sslp_pkg::stage_hs_t hs;
  sslp_pkg::event_t    ev;

  sslp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register: takes a beat when empty or when its beat moves on.
  assign s_axis_tready = !in_valid_q || take;

  always_comb begin
    in_valid_d = in_valid_q;
    in_beat_d  = in_beat_q;
    if (take) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d               = 1'b1;
      in_beat_d.data_byte      = s_axis_tdata;
      in_beat_d.end_of_message = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_beat_q <= in_beat_d;
  end

  assign hs.valid = in_valid_q;
  assign hs.ready = m_axis_tready;

  sslp_parser #(
    .LED_COUNT  (LED_COUNT),
    .PREFIX_MAX (PREFIX_MAX)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .beat_i      (in_beat_q),
    .hs_i        (hs),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .event_o     (ev)
  );

  // Pack the event beat.
  assign m_axis_tuser = ev.event_kind;
  assign m_axis_tdata = {5'd0, ev.blue_component, ev.green_level, ev.level_or_red,
                         ev.led_index};

endmodule

[dv/tb_sysex_led_command_parser_top.sv]
// Self-checking testbench for the system-exclusive LED command parser top level.
// Depends on sslp_pkg and sysex_led_command_parser_top, which brings in its own submodules.
// Message bytes are sent with random gaps and stalls, and every event is checked against a predictor.
module tb_sysex_led_command_parser_top;

  localparam int LedCount      = 8;
  localparam int PrefixMax     = 8;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 2000;

  // Register addresses on the configuration port.
  localparam logic [3:0] AddrPrefixBytes  = 4'h0;
  localparam logic [3:0] AddrPrefixLength = 4'h8;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [2:0] led_index, [10:3] level_or_red,
                               // [18:11] green_level, [26:19] blue_component
  logic [2:0]  m_axis_tuser;   // [2:0] event_kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  // Predictor copy of the configuration and the parse state.
  sslp_pkg::cfg_t   active_cfg = '0;
  sslp_pkg::phase_e cur_phase = sslp_pkg::PhPrefix;
  logic [3:0]       match_pos = '0;
  logic [2:0]       pend_led = '0;
  logic [7:0]       pend_red = '0;
  logic [7:0]       pend_green = '0;
  logic [1:0]       rgb_count = '0;

  sslp_pkg::event_t expected_events[$];
  logic [7:0]       msg_bytes[$];
  int               bytes_sent = 0;
  int               failures = 0;
  int               sender_idle_pct = 0;
  int               receiver_stall_pct = 0;
  int               quiet_cycles = 0;

  sysex_led_command_parser_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock with a period of 10.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic sslp_pkg::event_t make_event(input sslp_pkg::kind_e kind,
                                                  input logic [2:0] led,
                                                  input logic [7:0] a, input logic [7:0] g,
                                                  input logic [7:0] b);
    sslp_pkg::event_t ev;
    ev.event_kind     = kind;
    ev.led_index      = led;
    ev.level_or_red   = a;
    ev.green_level    = g;
    ev.blue_component = b;
    return ev;
  endfunction

  // Prefix length as the parser uses it, saturated at the maximum.
  function automatic int prefix_len_sat();
    return (active_cfg.prefix_length > PrefixMax) ? PrefixMax : int'(active_cfg.prefix_length);
  endfunction

  function automatic logic [7:0] prefix_byte(input int i);
    return active_cfg.prefix_bytes[8*i +: 8];
  endfunction

  // A byte in command position: start a command, emit an event or stop.
  task automatic decode_command(input logic [7:0] b, input logic eom);
    if (b == sslp_pkg::ByteEnd) begin
      cur_phase = sslp_pkg::PhStop;
    end else if (b == sslp_pkg::CmdBeat) begin
      expected_events.push_back(make_event(sslp_pkg::KindBeat, 3'd0, 8'd0, 8'd0, 8'd0));
    end else if (b == sslp_pkg::CmdOrange) begin
      if (eom) begin
        cur_phase = sslp_pkg::PhStop;
        expected_events.push_back(make_event(sslp_pkg::KindError, 3'd0, 8'd0, 8'd0, 8'd0));
      end else begin
        cur_phase = sslp_pkg::PhOrange;
      end
    end else if (b == sslp_pkg::CmdBlue) begin
      cur_phase = eom ? sslp_pkg::PhStop : sslp_pkg::PhBlue;
    end else if (b == sslp_pkg::CmdError || b < sslp_pkg::CmdRgb ||
                 int'(b - sslp_pkg::CmdRgb) >= LedCount || eom) begin
      cur_phase = sslp_pkg::PhStop;
      expected_events.push_back(make_event(sslp_pkg::KindError, 3'd0, 8'd0, 8'd0, 8'd0));
    end else begin
      pend_led  = 3'(b - sslp_pkg::CmdRgb);
      rgb_count = '0;
      cur_phase = sslp_pkg::PhColor;
    end
  endtask

  // Advance the predictor by one accepted byte and queue the event it completes.
  task automatic predict_event(input logic [7:0] b, input logic eom);
    logic [7:0] want;
    case (cur_phase)
      sslp_pkg::PhPrefix: begin
        if (int'(match_pos) < prefix_len_sat()) begin
          want = prefix_byte(int'(match_pos[2:0]));
          if (b != want) cur_phase = sslp_pkg::PhStop;
          else match_pos = match_pos + 4'd1;
        end else begin
          cur_phase = sslp_pkg::PhCmd;
          decode_command(b, eom);
        end
      end
      sslp_pkg::PhCmd: begin
        decode_command(b, eom);
      end
      sslp_pkg::PhOrange: begin
        cur_phase = sslp_pkg::PhCmd;
        expected_events.push_back(make_event(sslp_pkg::KindOrange, 3'd0, b, 8'd0, 8'd0));
      end
      sslp_pkg::PhBlue: begin
        cur_phase = sslp_pkg::PhCmd;
        expected_events.push_back(make_event(sslp_pkg::KindBlue, 3'd0, b, 8'd0, 8'd0));
      end
      sslp_pkg::PhColor: begin
        if (rgb_count < 2'd2) begin
          if (rgb_count == 2'd0) pend_red = b;
          else pend_green = b;
          rgb_count = rgb_count + 2'd1;
          if (eom) begin
            cur_phase = sslp_pkg::PhStop;
            expected_events.push_back(make_event(sslp_pkg::KindError, 3'd0, 8'd0, 8'd0,
                                                 8'd0));
          end
        end else begin
          rgb_count = '0;
          cur_phase = sslp_pkg::PhCmd;
          expected_events.push_back(make_event(sslp_pkg::KindColor, pend_led, pend_red,
                                               pend_green, b));
        end
      end
      default: begin
      end
    endcase
    // The end of a message always returns to prefix matching.
    if (eom) begin
      cur_phase = sslp_pkg::PhPrefix;
      match_pos = '0;
      rgb_count = '0;
    end
  endtask

  // Send one byte, with random idle cycles in front of it.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    predict_event(value, last);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  // Stop sending and wait until every event has come out and the pipeline is empty.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrPrefixBytes) active_cfg.prefix_bytes = value;
    else if (addr == AddrPrefixLength) active_cfg.prefix_length = value[3:0];
  endtask

  task automatic configure(input logic [63:0] prefix, input logic [3:0] length);
    wait_for_drain();
    write_reg(AddrPrefixBytes, prefix);
    write_reg(AddrPrefixLength, {60'd0, length});
  endtask

  // Data byte biased towards the extremes and the stop byte.
  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return sslp_pkg::ByteEnd;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_junk();
    repeat ($urandom_range(0, 2)) msg_bytes.push_back(rand_data());
  endtask

  task automatic add_good_command();
    case ($urandom_range(0, 4))
      0: msg_bytes.push_back(sslp_pkg::CmdBeat);
      1: begin
        msg_bytes.push_back(sslp_pkg::CmdOrange);
        msg_bytes.push_back(rand_data());
      end
      2: begin
        msg_bytes.push_back(sslp_pkg::CmdBlue);
        msg_bytes.push_back(rand_data());
      end
      default: begin
        msg_bytes.push_back(8'(sslp_pkg::CmdRgb + $urandom_range(0, LedCount - 1)));
        repeat (3) msg_bytes.push_back(rand_data());
      end
    endcase
  endtask

  // Ending that cuts a command short, reports an error or stops parsing.
  task automatic add_bad_tail();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: msg_bytes.push_back(sslp_pkg::CmdOrange);
      1: msg_bytes.push_back(sslp_pkg::CmdBlue);
      2: begin
        msg_bytes.push_back(8'(sslp_pkg::CmdRgb + $urandom_range(0, LedCount - 1)));
        repeat ($urandom_range(0, 2)) msg_bytes.push_back(rand_data());
      end
      3: begin
        msg_bytes.push_back(sslp_pkg::CmdError);
        add_junk();
      end
      4: begin
        do b = 8'($urandom_range(0, 255));
        while ((b >= sslp_pkg::CmdRgb && int'(b) < int'(sslp_pkg::CmdRgb) + LedCount) ||
               (b inside {sslp_pkg::CmdOrange, sslp_pkg::CmdBlue, sslp_pkg::CmdError,
                          sslp_pkg::CmdBeat, sslp_pkg::ByteEnd}));
        msg_bytes.push_back(b);
        add_junk();
      end
      default: begin
        msg_bytes.push_back(sslp_pkg::ByteEnd);
        add_junk();
      end
    endcase
  endtask

  // Mostly well-formed messages, the rest broken prefixes, short messages and noise.
  task automatic build_message();
    int plen;
    int pick;
    int n;
    int bad_pos;
    plen = prefix_len_sat();
    pick = $urandom_range(0, 99);
    msg_bytes.delete();
    if (pick < 78) begin
      for (int i = 0; i < plen; i++) msg_bytes.push_back(prefix_byte(i));
      repeat ($urandom_range(1, 5)) add_good_command();
      if ($urandom_range(0, 4) == 0) add_bad_tail();
    end else if (pick < 86 && plen > 0) begin
      bad_pos = $urandom_range(0, plen - 1);
      for (int i = 0; i < plen; i++) begin
        msg_bytes.push_back((i == bad_pos) ? prefix_byte(i) ^ 8'($urandom_range(1, 255))
                                           : prefix_byte(i));
      end
      add_good_command();
    end else if (pick < 92 && plen > 1) begin
      n = $urandom_range(1, plen - 1);
      for (int i = 0; i < n; i++) msg_bytes.push_back(prefix_byte(i));
    end else begin
      repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Every command with extreme values, no prefix.
  task automatic test_basic_commands();
    configure(64'd0, 4'd0);
    msg_bytes = '{sslp_pkg::CmdBeat};
    send_message();
    msg_bytes = '{sslp_pkg::CmdOrange, 8'h00, sslp_pkg::CmdBlue, 8'hFF};
    send_message();
    msg_bytes = '{8'(sslp_pkg::CmdRgb + LedCount - 1), 8'hFF, 8'h00, sslp_pkg::ByteEnd};
    send_message();
  endtask

  // Truncated commands, the error command, bad commands and the stop byte.
  task automatic test_special_cases();
    msg_bytes = '{sslp_pkg::CmdOrange};
    send_message();
    msg_bytes = '{sslp_pkg::CmdBlue};
    send_message();
    msg_bytes = '{sslp_pkg::CmdRgb, 8'h11, 8'h22};
    send_message();
    msg_bytes = '{sslp_pkg::CmdError, sslp_pkg::CmdBeat};
    send_message();
    msg_bytes = '{8'h12};
    send_message();
    msg_bytes = '{8'(sslp_pkg::CmdRgb + LedCount)};
    send_message();
    msg_bytes = '{sslp_pkg::ByteEnd, sslp_pkg::CmdBeat};
    send_message();
  endtask

  // A length above the maximum matches eight prefix bytes only.
  task automatic test_prefix_saturation();
    configure(64'h7F00_FF55_AA01_F740, 4'd15);
    msg_bytes.delete();
    for (int i = 0; i < PrefixMax; i++) msg_bytes.push_back(prefix_byte(i));
    msg_bytes.push_back(sslp_pkg::CmdBeat);
    send_message();
  endtask

  task automatic test_random_traffic(input logic [63:0] prefix, input logic [3:0] length,
                                     input int idle_pct, input int stall_pct,
                                     input int items);
    int stop_at;
    configure(prefix, length);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    stop_at = bytes_sent + items;
    while (bytes_sent < stop_at) begin
      build_message();
      send_message();
    end
  endtask

  // Result side: random stalls and a check of every event beat.
  always @(posedge clk_i) begin
    sslp_pkg::event_t exp_ev;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d, data 0x%08h", m_axis_tuser, m_axis_tdata);
        failures++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (m_axis_tuser != exp_ev.event_kind) begin
          $error("event_kind: expected %0d, got %0d", exp_ev.event_kind, m_axis_tuser);
          failures++;
        end
        if (m_axis_tdata[2:0] != exp_ev.led_index) begin
          $error("led_index: expected %0d, got %0d", exp_ev.led_index, m_axis_tdata[2:0]);
          failures++;
        end
        if (m_axis_tdata[10:3] != exp_ev.level_or_red) begin
          $error("level_or_red: expected 0x%02h, got 0x%02h",
                 exp_ev.level_or_red, m_axis_tdata[10:3]);
          failures++;
        end
        if (m_axis_tdata[18:11] != exp_ev.green_level) begin
          $error("green_level: expected 0x%02h, got 0x%02h",
                 exp_ev.green_level, m_axis_tdata[18:11]);
          failures++;
        end
        if (m_axis_tdata[26:19] != exp_ev.blue_component) begin
          $error("blue_component: expected 0x%02h, got 0x%02h",
                 exp_ev.blue_component, m_axis_tdata[26:19]);
          failures++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Watchdog: ends the run when no beat has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("** sysex_led_command_parser_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_special_cases();
    test_prefix_saturation();
    test_random_traffic(64'd0, 4'd0, 0, 0, 480);
    test_random_traffic({64{1'b1}}, 4'd8, 45, 0, 480);
    test_random_traffic({$urandom, $urandom}, 4'd15, 0, 45, 480);
    test_random_traffic({$urandom, $urandom}, 4'd3, 34, 34, 480);

    wait_for_drain();
    if (failures == 0) begin
      $display("** sysex_led_command_parser_top: PASSED **");
    end else begin
      $display("** sysex_led_command_parser_top: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sslp_pkg.sv
sv/sslp_cfg_regs.sv
sv/sslp_parser.sv
sv/sysex_led_command_parser_top.sv
dv/tb_sysex_led_command_parser_top.sv
